### rtl/core/rmrc_pkg.sv
package rmrc_pkg;

  localparam int NUM_MODULI    = 4;
  localparam int RESIDUE_WIDTH = 8;
  localparam int LANE_IDX_W    = $clog2(NUM_MODULI);
  localparam int COUNT_W       = 3;
  localparam int TABLE_W       = 48;
  localparam int CFG_DATA_W    = 48;
  localparam int NUM_REGS      = NUM_MODULI + 2;
  localparam int CFG_IDX_W     = $clog2(NUM_REGS);

  // One round: entry stage, RESIDUE_WIDTH+1 reduce cells, multiply, RESIDUE_WIDTH reduce cells
  localparam int ROUND_STAGES  = 2 * RESIDUE_WIDTH + 3;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(NUM_MODULI);
  localparam logic [CFG_IDX_W-1:0] REG_TABLE = CFG_IDX_W'(NUM_MODULI + 1);

  typedef logic [RESIDUE_WIDTH-1:0] residue_t;
  typedef residue_t [NUM_MODULI-1:0] lane_vec_t;

  localparam lane_vec_t MODULUS_RESET = {
    residue_t'(19), residue_t'(17), residue_t'(15), residue_t'(13)
  };
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);
  localparam logic [TABLE_W-1:0] TABLE_RESET = 48'h090E08030407;

  typedef struct packed {
    residue_t residue_3;
    residue_t residue_2;
    residue_t residue_1;
    residue_t residue_0;
  } in_item_t;

  typedef struct packed {
    logic     out_of_range;
    residue_t digit_3;
    residue_t digit_2;
    residue_t digit_1;
    residue_t digit_0;
  } out_item_t;

endpackage

### rtl/core/residue_mixed_radix_conversion.sv
// Channel   Handshake                  Payload
// cfg       cfg_we_i                   cfg_idx_i, cfg_data_i
// in        in_valid_i / in_ready_o    in_data_i (residue_0..3)
// out       out_valid_o / out_ready_i  out_data_o (digit_0..3, out_of_range)
//
// One item per cycle unless the output stalls; each item passes the input register,
// single-step reduce cells with one multiply cell per round, and the output register.
// Reset loads the default moduli, count and inverse table; no clearing pass.
// The whole chain holds only when the output register is full, not taken, and the
// last cell holds a result; bubbles keep draining into the output register.
module residue_mixed_radix_conversion (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmrc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rmrc_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rmrc_pkg::out_item_t             out_data_o
);
  import rmrc_pkg::*;

  localparam int Total = 1 + (NUM_MODULI - 1) * ROUND_STAGES;

  lane_vec_t            mod_q;
  logic [COUNT_W-1:0]   count_q;
  logic [TABLE_W-1:0]   table_q;
  logic [COUNT_W-1:0]   n_eff;

  lane_vec_t            in_lane;
  logic                 in_bad;
  logic                 adv;

  lane_vec_t            lane0_q;
  logic [Total-1:0]     vld_q;
  logic [Total-1:0]     bad_q;
  lane_vec_t            chain [NUM_MODULI];

  lane_vec_t            dig;
  out_item_t            out_d;
  out_item_t            out_q;
  logic                 out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= MODULUS_RESET;
      count_q <= COUNT_RESET;
      table_q <= TABLE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < REG_COUNT) begin
        mod_q[cfg_idx_i[LANE_IDX_W-1:0]] <= cfg_data_i[RESIDUE_WIDTH-1:0];
      end else if (cfg_idx_i == REG_COUNT) begin
        count_q <= cfg_data_i[COUNT_W-1:0];
      end else if (cfg_idx_i == REG_TABLE) begin
        table_q <= cfg_data_i[TABLE_W-1:0];
      end
    end
  end

  always_comb begin
    if (count_q == '0) begin
      n_eff = COUNT_W'(1);
    end else if (count_q > COUNT_W'(NUM_MODULI)) begin
      n_eff = COUNT_W'(NUM_MODULI);
    end else begin
      n_eff = count_q;
    end
  end

  assign in_lane = {in_data_i.residue_3, in_data_i.residue_2,
                    in_data_i.residue_1, in_data_i.residue_0};

  always_comb begin
    in_bad = 1'b0;
    for (int k = 0; k < NUM_MODULI; k++) begin
      if ((COUNT_W'(k) < n_eff) && (in_lane[k] >= mod_q[k])) begin
        in_bad = 1'b1;
      end
    end
  end

  assign adv        = !vld_q[Total-1] || !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Total-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bad_q   <= {bad_q[Total-2:0], in_bad};
      lane0_q <= in_lane;
    end
  end

  assign chain[0] = lane0_q;

  for (genvar j = 0; j < NUM_MODULI - 1; j++) begin : g_round
    rmrc_round #(
      .J (j)
    ) u_round (
      .clk_i       (clk_i),
      .en_i        (adv),
      .mod_i       (mod_q),
      .inv_table_i (table_q),
      .lane_i      (chain[j]),
      .lane_o      (chain[j+1])
    );
  end

  always_comb begin
    for (int k = 0; k < NUM_MODULI; k++) begin
      dig[k] = (bad_q[Total-1] || (COUNT_W'(k) >= n_eff)) ? '0 : chain[NUM_MODULI-1][k];
    end
  end

  always_comb begin
    out_d.digit_0      = dig[0];
    out_d.digit_1      = dig[1];
    out_d.digit_2      = dig[2];
    out_d.digit_3      = dig[3];
    out_d.out_of_range = bad_q[Total-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && vld_q[Total-1]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[Total-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_blocks_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Total-1] && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("intake open while the last cell cannot drain");

  a_drain_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[Total-1]) |=> out_valid_o)
    else $error("result from the last cell lost");

  a_range_zeroes_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_of_range) |->
    (out_data_o.digit_0 == '0 && out_data_o.digit_1 == '0 &&
     out_data_o.digit_2 == '0 && out_data_o.digit_3 == '0))
    else $error("flagged transfer carries nonzero digits");

endmodule

### rtl/core/rmrc_sub_cell.sv
module rmrc_sub_cell #(
  parameter int BusW  = 17,
  parameter int Shift = 0
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [rmrc_pkg::RESIDUE_WIDTH-1:0] q_i,
  input  logic [BusW-1:0]                x_i,
  output logic [BusW-1:0]                x_o
);
  import rmrc_pkg::*;

  localparam int InW  = RESIDUE_WIDTH + Shift + 1;
  localparam int OutW = RESIDUE_WIDTH + Shift;

  logic [InW-1:0]  x_in;
  logic [InW-1:0]  q_sh;
  logic [InW-1:0]  diff;
  logic [OutW-1:0] x_d;
  logic [OutW-1:0] x_q;

  assign x_in = x_i[InW-1:0];
  assign q_sh = InW'(q_i) << Shift;
  assign diff = x_in - q_sh;
  assign x_d  = (x_in >= q_sh) ? diff[OutW-1:0] : x_in[OutW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
    end
  end

  assign x_o = BusW'(x_q);

endmodule

### rtl/core/rmrc_mul_cell.sv
module rmrc_mul_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [rmrc_pkg::RESIDUE_WIDTH-1:0]   a_i,
  input  logic [rmrc_pkg::RESIDUE_WIDTH-1:0]   b_i,
  output logic [2*rmrc_pkg::RESIDUE_WIDTH-1:0] p_o
);
  import rmrc_pkg::*;

  logic [2*RESIDUE_WIDTH-1:0] p_d;
  logic [2*RESIDUE_WIDTH-1:0] p_q;

  assign p_d = (2*RESIDUE_WIDTH)'(a_i) * (2*RESIDUE_WIDTH)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/rmrc_round.sv
module rmrc_round #(
  parameter int J = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  rmrc_pkg::lane_vec_t          mod_i,
  input  logic [rmrc_pkg::TABLE_W-1:0] inv_table_i,
  input  rmrc_pkg::lane_vec_t          lane_i,
  output rmrc_pkg::lane_vec_t          lane_o
);
  import rmrc_pkg::*;

  localparam int EntW  = 2 * RESIDUE_WIDTH + 1;
  localparam int ProdW = 2 * RESIDUE_WIDTH;

  for (genvar k = 0; k < NUM_MODULI; k++) begin : g_lane
    if (k <= J) begin : g_hold
      residue_t [ROUND_STAGES-1:0] dly_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dly_q <= {dly_q[ROUND_STAGES-2:0], lane_i[k]};
        end
      end

      assign lane_o[k] = dly_q[ROUND_STAGES-1];
    end else begin : g_work
      localparam int Idx = J * (2 * NUM_MODULI - J - 1) / 2 + (k - J - 1);
      localparam int Pos = Idx * RESIDUE_WIDTH;

      residue_t                               inv;
      logic [EntW-1:0]                        ent_d;
      logic [EntW-1:0]                        ent_q;
      logic [RESIDUE_WIDTH+1:0][EntW-1:0]     p1;
      logic [RESIDUE_WIDTH:0][ProdW-1:0]      p2;

      if (Pos >= TABLE_W) begin : g_inv_zero
        assign inv = '0;
      end else begin : g_inv
        assign inv = RESIDUE_WIDTH'(inv_table_i >> Pos);
      end

      // v + (q << w) - d stays positive and below 2q << w
      assign ent_d = EntW'({mod_i[k], {RESIDUE_WIDTH{1'b0}}}) + EntW'(lane_i[k])
                     - EntW'(lane_i[J]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ent_q <= ent_d;
        end
      end

      assign p1[RESIDUE_WIDTH+1] = ent_q;

      for (genvar s = RESIDUE_WIDTH; s >= 0; s--) begin : g_red_a
        rmrc_sub_cell #(
          .BusW  (EntW),
          .Shift (s)
        ) u_cell (
          .clk_i (clk_i),
          .en_i  (en_i),
          .q_i   (mod_i[k]),
          .x_i   (p1[s+1]),
          .x_o   (p1[s])
        );
      end

      rmrc_mul_cell u_mul (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (p1[0][RESIDUE_WIDTH-1:0]),
        .b_i   (inv),
        .p_o   (p2[RESIDUE_WIDTH])
      );

      for (genvar s = RESIDUE_WIDTH - 1; s >= 0; s--) begin : g_red_b
        rmrc_sub_cell #(
          .BusW  (ProdW),
          .Shift (s)
        ) u_cell (
          .clk_i (clk_i),
          .en_i  (en_i),
          .q_i   (mod_i[k]),
          .x_i   (p2[s+1]),
          .x_o   (p2[s])
        );
      end

      assign lane_o[k] = p2[0][RESIDUE_WIDTH-1:0];
    end
  end

endmodule
